>>> src/bteh_pkg.sv
// Shared constants for the base-triple error histogram block.
// No dependencies; used by the top level by scoped names.
package bteh_pkg;

  localparam int NumBins       = 125;
  localparam int NumIndDefault = 64;
  localparam int CountWDefault = 32;
  localparam int ReportW       = 32;
  localparam int RawAddrW      = 13;

  localparam logic [7:0] MinQualityReset    = 8'd13;
  localparam logic       FirstReadOnlyReset = 1'b1;

  localparam logic [1:0] OP_OBSERVE = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  localparam logic CFG_MIN_QUALITY     = 1'b0;
  localparam logic CFG_FIRST_READ_ONLY = 1'b1;

  localparam logic [2:0] BASE_N = 3'd4;

  function automatic logic [2:0] base_code(input logic [2:0] b);
    return (b > BASE_N) ? BASE_N : b;
  endfunction

endpackage

>>> src/base_triple_error_histogram.sv
// Per-individual base-triple error histograms (total and per chromosome).
// Depends on bteh_pkg and bteh_ram.
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_ready_o  | operation_i .. bin_select_i
//  out     | output    | out_valid_o/out_ready_i| total_count_o, chromosome_count_o, counted_o
//  cfg     | input     | cfg_we_i               | cfg_index_i, cfg_data_i
//
// An observe, read or unused-code beat is accepted with the RAM read, then updated,
// written back and loaded into the output register. A clear sweeps the chromosome
// RAM, then passes through the update stage for its result.
// After reset both RAMs are zeroed with in_ready_o low.
// A stalled output holds the update stage; the output register lets the next beat in.
module base_triple_error_histogram #(
  parameter int NUM_INDIVIDUALS = bteh_pkg::NumIndDefault,
  parameter int COUNT_WIDTH     = bteh_pkg::CountWDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [5:0]  individual_i,
  input  logic [2:0]  ancestral_base_i,
  input  logic [2:0]  reference_base_i,
  input  logic [2:0]  observed_base_i,
  input  logic [7:0]  quality_i,
  input  logic        group_start_i,
  input  logic        site_kept_i,
  input  logic [6:0]  bin_select_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] total_count_o,
  output logic [31:0] chromosome_count_o,
  output logic        counted_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  localparam int Depth = NUM_INDIVIDUALS * bteh_pkg::NumBins;
  localparam int AW    = $clog2(Depth);
  localparam int RW    = bteh_pkg::RawAddrW;
  localparam logic [AW-1:0] LastAddr = AW'(Depth - 1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_MOD   = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic        clr_all_q, clr_all_d;
  logic [1:0]  op_q;
  logic [AW-1:0] addr_q;
  logic        in_range_q, hit_q, gstart_q;
  logic        group_taken_q, group_taken_d;
  logic [7:0]  min_quality_q;
  logic        first_read_only_q;
  logic        out_valid_q, out_valid_d;
  logic [31:0] total_q, chrom_q;
  logic        counted_q;

  logic        accept, go, do_inc, gt, in_range, rd_en;
  logic [6:0]  obs_bin, sel_bin;
  logic [RW-1:0] raw_addr;
  logic [AW-1:0] rd_addr, wr_addr;
  logic        tot_we, chr_we;
  logic [COUNT_WIDTH-1:0] tot_rd, chr_rd, tot_new, chr_new, tot_wd, chr_wd;
  logic [COUNT_WIDTH-1:0] tot_val, chr_val;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (&v) ? v : v + COUNT_WIDTH'(1);
  endfunction

  function automatic logic [31:0] report(input logic [COUNT_WIDTH-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return (|w[63:32]) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  assign obs_bin = 7'(bteh_pkg::base_code(ancestral_base_i) * 7'd25)
                 + 7'(bteh_pkg::base_code(reference_base_i) * 7'd5)
                 + 7'(bteh_pkg::base_code(observed_base_i));
  assign sel_bin  = (operation_i == bteh_pkg::OP_READ) ? bin_select_i : obs_bin;
  assign raw_addr = RW'(individual_i) * RW'(bteh_pkg::NumBins) + RW'(sel_bin);
  assign rd_addr  = AW'(raw_addr);

  always_comb begin
    in_range = 1'b0;
    unique case (operation_i)
      bteh_pkg::OP_OBSERVE: in_range = 32'(individual_i) < NUM_INDIVIDUALS;
      bteh_pkg::OP_READ:    in_range = (32'(individual_i) < NUM_INDIVIDUALS) &&
                                       (32'(bin_select_i) < bteh_pkg::NumBins);
      default:              in_range = 1'b0;
    endcase
  end

  assign rd_en = accept && in_range;

  assign go      = (state_q == S_MOD) && (!out_valid_q || out_ready_i);
  assign gt      = gstart_q ? 1'b0 : group_taken_q;
  assign do_inc  = (op_q == bteh_pkg::OP_OBSERVE) && in_range_q && hit_q &&
                   !(first_read_only_q && gt);
  assign tot_new = sat_inc(tot_rd);
  assign chr_new = sat_inc(chr_rd);

  assign tot_we  = ((state_q == S_CLEAR) && clr_all_q) || (go && do_inc);
  assign chr_we  = (state_q == S_CLEAR) || (go && do_inc);
  assign wr_addr = (state_q == S_CLEAR) ? cnt_q : addr_q;
  assign tot_wd  = (state_q == S_CLEAR) ? '0 : tot_new;
  assign chr_wd  = (state_q == S_CLEAR) ? '0 : chr_new;

  assign tot_val = !in_range_q ? '0 : (do_inc ? tot_new : tot_rd);
  assign chr_val = !in_range_q ? '0 : (do_inc ? chr_new : chr_rd);

  bteh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(Depth)) u_total_ram (
    .clk_i   (clk_i),
    .we_i    (tot_we),
    .waddr_i (wr_addr),
    .wdata_i (tot_wd),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (tot_rd)
  );

  bteh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(Depth)) u_chrom_ram (
    .clk_i   (clk_i),
    .we_i    (chr_we),
    .waddr_i (wr_addr),
    .wdata_i (chr_wd),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (chr_rd)
  );

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    clr_all_d     = clr_all_q;
    group_taken_d = group_taken_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_CLEAR: begin
        cnt_d = cnt_q + AW'(1);
        if (cnt_q == LastAddr) begin
          cnt_d   = '0;
          state_d = clr_all_q ? S_IDLE : S_MOD;
          clr_all_d = 1'b0;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = (operation_i == bteh_pkg::OP_CLEAR) ? S_CLEAR : S_MOD;
          cnt_d   = '0;
        end
      end
      S_MOD: begin
        if (go) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          if (op_q == bteh_pkg::OP_OBSERVE) begin
            group_taken_d = do_inc ? 1'b1 : gt;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= S_CLEAR;
      cnt_q             <= '0;
      clr_all_q         <= 1'b1;
      group_taken_q     <= 1'b0;
      out_valid_q       <= 1'b0;
      min_quality_q     <= bteh_pkg::MinQualityReset;
      first_read_only_q <= bteh_pkg::FirstReadOnlyReset;
    end else begin
      state_q       <= state_d;
      cnt_q         <= cnt_d;
      clr_all_q     <= clr_all_d;
      group_taken_q <= group_taken_d;
      out_valid_q   <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          bteh_pkg::CFG_MIN_QUALITY:     min_quality_q     <= cfg_data_i;
          bteh_pkg::CFG_FIRST_READ_ONLY: first_read_only_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= operation_i;
      addr_q     <= rd_addr;
      in_range_q <= in_range;
      hit_q      <= site_kept_i && (quality_i >= min_quality_q);
      gstart_q   <= group_start_i;
    end
    if (go) begin
      total_q   <= report(tot_val);
      chrom_q   <= report(chr_val);
      counted_q <= do_inc;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign total_count_o      = total_q;
  assign chromosome_count_o = chrom_q;
  assign counted_o          = counted_q;

endmodule

>>> src/bteh_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module bteh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/bteh_checker.sv
// Port-level checks for base_triple_error_histogram, bound to the top level.
// Depends on the top level's port names only.
module bteh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] total_count_o,
  input logic [31:0] chromosome_count_o,
  input logic        counted_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(total_count_o) &&
    $stable(chromosome_count_o) && $stable(counted_o))
    else $error("result beat changed while stalled");

  a_counted_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && counted_o |-> total_count_o != 32'd0 && chromosome_count_o != 32'd0)
    else $error("counted beat shows a zero count");

  a_chrom_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> chromosome_count_o <= total_count_o)
    else $error("chromosome count above total count");

  a_reset_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_ready_o && !out_valid_o)
    else $error("block ready or valid during reset sweep");

endmodule

bind base_triple_error_histogram bteh_checker u_bteh_checker (.*);
